// File: src/aavr_pkg.sv
// package for the axis-angle vector rotation unit
// constants, cordic arctangent table and fixed-point helpers; no dependencies
package aavr_pkg;

  localparam int ANGLE_BITS  = 16;
  localparam int TRIG_STAGES = 16;
  localparam int CORDIC_N    = (TRIG_STAGES < 24) ? TRIG_STAGES : 24;
  localparam int CW          = 34;

  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [32:0] zw_t;

  typedef struct packed {
    logic signed [15:0] kx;
    logic signed [15:0] ky;
    logic signed [15:0] kz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } carry_t;

  function automatic zw_t atan_turn(input int i);
    zw_t r;
    case (i)
      0: r = 33'sd536870912;   1: r = 33'sd316933406;
      2: r = 33'sd167458907;   3: r = 33'sd85004756;
      4: r = 33'sd42667331;    5: r = 33'sd21354465;
      6: r = 33'sd10679838;    7: r = 33'sd5340245;
      8: r = 33'sd2670163;     9: r = 33'sd1335087;
      10: r = 33'sd667544;     11: r = 33'sd333772;
      12: r = 33'sd166886;     13: r = 33'sd83443;
      14: r = 33'sd41722;      15: r = 33'sd20861;
      16: r = 33'sd10430;      17: r = 33'sd5215;
      18: r = 33'sd2608;       19: r = 33'sd1304;
      20: r = 33'sd652;        21: r = 33'sd326;
      22: r = 33'sd163;        23: r = 33'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic cw_t clamp_q30(input logic signed [63:0] v);
    cw_t r;
    if (v > 64'sd1073741824) r = ONE_Q30;
    else if (v < -64'sd1073741824) r = -ONE_Q30;
    else r = cw_t'(v);
    return r;
  endfunction

endpackage

// File: src/axis_angle_vector_rotate_unit.sv
// axis-angle vector rotation unit, top level
// depends on aavr_pkg for constants, the arctangent table and helpers
//
// usage: drive angle, axis and vector with start high; a request is taken at
// every clock edge where start is high and busy is low. busy is always low,
// so one request may enter in every cycle.
// pipeline: an entry register, one register stage per cordic iteration (CORDIC_N = 16), then
// an axis-product stage, a scale-by-(1-c) and sine stage, a matrix-entry
// stage, a row-product stage and an output round/saturate stage.
// throughput: one result per cycle, set by the cordic stage chain.
// each result shows on out_x/out_y/out_z/saturated for one cycle with
// done high; the receiver cannot stall, so the pipeline never holds.
// reset (rst, synchronous) clears every valid bit; data registers keep
// whatever they had and are ignored until a new request reaches them.
module axis_angle_vector_rotate_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic        [15:0] angle,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  output logic               done,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               saturated
);

  localparam int N = aavr_pkg::CORDIC_N;

  assign busy = 1'b0;

  // cordic stage registers; index 0 is the entry stage
  aavr_pkg::cw_t    cx [N+1];
  aavr_pkg::cw_t    cy [N+1];
  aavr_pkg::zw_t    cz [N+1];
  logic             cflip [N+1];
  aavr_pkg::carry_t cc [N+1];
  logic             cv [N+1];

  // entry: place angle in a turn word and fold into the right half plane
  logic [31:0] turn;
  logic [1:0]  quad;
  logic        flip_in;
  logic [31:0] turn_f;
  always_comb begin
    turn    = {angle[aavr_pkg::ANGLE_BITS-1:0], {(32-aavr_pkg::ANGLE_BITS){1'b0}}};
    quad    = turn[31:30];
    flip_in = (quad == 2'd1) || (quad == 2'd2);
    turn_f  = flip_in ? turn + 32'h8000_0000 : turn;
  end

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else cv[0] <= start;
    cx[0]    <= aavr_pkg::CORDIC_K;
    cy[0]    <= '0;
    cz[0]    <= {turn_f[31], turn_f};
    cflip[0] <= flip_in;
    cc[0]    <= '{kx: axis_x, ky: axis_y, kz: axis_z, vx: vec_x, vy: vec_y, vz: vec_z};
  end

  // one micro-rotation per stage; >>> on signed is a floor shift
  for (genvar i = 0; i < N; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else cv[i+1] <= cv[i];
      if (!cz[i][32]) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - aavr_pkg::atan_turn(i);
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + aavr_pkg::atan_turn(i);
      end
      cflip[i+1] <= cflip[i];
      cc[i+1]    <= cc[i];
    end
  end

  // stage a: unflip/clamp c, s and form axis products (Q4.28)
  logic signed [31:0] c_a, s_a;
  logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz;
  aavr_pkg::carry_t   ca;
  logic               va;
  logic signed [63:0] xf, yf;
  always_comb begin
    xf = cflip[N] ? -64'(cx[N]) : 64'(cx[N]);
    yf = cflip[N] ? -64'(cy[N]) : 64'(cy[N]);
  end
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else va <= cv[N];
    c_a <= 32'(aavr_pkg::clamp_q30(xf));
    s_a <= 32'(aavr_pkg::clamp_q30(yf));
    pxx <= cc[N].kx * cc[N].kx;
    pyy <= cc[N].ky * cc[N].ky;
    pzz <= cc[N].kz * cc[N].kz;
    pxy <= cc[N].kx * cc[N].ky;
    pxz <= cc[N].kx * cc[N].kz;
    pyz <= cc[N].ky * cc[N].kz;
    ca  <= cc[N];
  end

  // stage b: scale by 1-c, sine terms, round to Q.30
  // 1-c reaches 2.0 when c is -1, so it needs a 33-bit signed word
  logic signed [32:0] omc;
  assign omc = 33'sd1073741824 - 33'(c_a);
  logic signed [63:0] txx, tyy, tzz, txy, txz, tyz, sx, sy, sz;
  logic signed [31:0] c_b;
  logic signed [31:0] vbx, vby, vbz;
  logic               vb;
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else vb <= va;
    txx <= (pxx * omc + 64'sd134217728) >>> 28;
    tyy <= (pyy * omc + 64'sd134217728) >>> 28;
    tzz <= (pzz * omc + 64'sd134217728) >>> 28;
    txy <= (pxy * omc + 64'sd134217728) >>> 28;
    txz <= (pxz * omc + 64'sd134217728) >>> 28;
    tyz <= (pyz * omc + 64'sd134217728) >>> 28;
    sx  <= (64'(s_a) * 64'(ca.kx) + 64'sd8192) >>> 14;
    sy  <= (64'(s_a) * 64'(ca.ky) + 64'sd8192) >>> 14;
    sz  <= (64'(s_a) * 64'(ca.kz) + 64'sd8192) >>> 14;
    c_b <= c_a;
    vbx <= ca.vx;
    vby <= ca.vy;
    vbz <= ca.vz;
  end

  // stage c: matrix entries, clamped to [-1, 1]
  aavr_pkg::cw_t m [9];
  logic signed [31:0] vcx, vcy, vcz;
  logic vc;
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else vc <= vb;
    m[0] <= aavr_pkg::clamp_q30(64'(c_b) + txx);
    m[1] <= aavr_pkg::clamp_q30(txy - sz);
    m[2] <= aavr_pkg::clamp_q30(txz + sy);
    m[3] <= aavr_pkg::clamp_q30(txy + sz);
    m[4] <= aavr_pkg::clamp_q30(64'(c_b) + tyy);
    m[5] <= aavr_pkg::clamp_q30(tyz - sx);
    m[6] <= aavr_pkg::clamp_q30(txz - sy);
    m[7] <= aavr_pkg::clamp_q30(tyz + sx);
    m[8] <= aavr_pkg::clamp_q30(64'(c_b) + tzz);
    vcx <= vbx;
    vcy <= vby;
    vcz <= vbz;
  end

  // stage d: nine products, 32 by 32
  logic signed [63:0] pr [9];
  logic vd;
  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else vd <= vc;
    for (int r = 0; r < 3; r++) begin
      pr[3*r]   <= 64'($signed(m[3*r][31:0])) * 64'(vcx);
      pr[3*r+1] <= 64'($signed(m[3*r+1][31:0])) * 64'(vcy);
      pr[3*r+2] <= 64'($signed(m[3*r+2][31:0])) * 64'(vcz);
    end
  end

  // stage e: sum, round, saturate
  logic signed [65:0] rs [3];
  logic [2:0] hi, lo;
  logic signed [31:0] rv [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rs[r] = (66'(pr[3*r]) + 66'(pr[3*r+1]) + 66'(pr[3*r+2]) + 66'sd536870912) >>> 30;
      hi[r] = rs[r] > 66'sd2147483647;
      lo[r] = rs[r] < -66'sd2147483648;
      rv[r] = hi[r] ? 32'sh7fff_ffff : (lo[r] ? 32'sh8000_0000 : rs[r][31:0]);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vd;
    out_x     <= rv[0];
    out_y     <= rv[1];
    out_z     <= rv[2];
    saturated <= |(hi | lo);
  end

  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    vc |=> vd ##1 done) else $error("valid lost in tail");
  a_entry: assert property (@(posedge clk) disable iff (rst)
    start |=> cv[0]) else $error("request dropped at entry");

endmodule

// File: test/tb_axis_angle_vector_rotate_unit.sv
// testbench for the axis-angle vector rotation unit
// depends on aavr_pkg and axis_angle_vector_rotate_unit; self-checking, no files
// requests go in on start/busy and every done result is checked against a predictor
`timescale 1ns / 100ps

module tb_axis_angle_vector_rotate_unit;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } rotated_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic        [15:0] angle;
  logic signed [15:0] axis_x, axis_y, axis_z;
  logic signed [31:0] vec_x, vec_y, vec_z;
  logic               done;
  logic signed [31:0] out_x, out_y, out_z;
  logic               saturated;

  // expected rotated vectors, oldest first
  rotated_t rotated_q[$];
  int       n_errors;
  int       n_requests;
  int       n_results;
  int       n_sat;
  int       cycle_count;
  bit       no_gaps;

  // arctangents in 2^-32 turn units
  localparam longint ATAN_TURNS [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };
  localparam longint Q30 = 64'sd1 << 30;

  axis_angle_vector_rotate_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .angle    (angle),
    .axis_x   (axis_x),
    .axis_y   (axis_y),
    .axis_z   (axis_z),
    .vec_x    (vec_x),
    .vec_y    (vec_y),
    .vec_z    (vec_z),
    .done     (done),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .saturated(saturated)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one output row: round Q.60 down to Q.30 and clip to 32 bits
  function automatic logic signed [31:0] rotate_row(input longint m0, m1, m2,
                                                    input longint v0, v1, v2,
                                                    inout logic sat);
    longint acc;
    acc = (m0 * v0 + m1 * v1 + m2 * v2 + (64'sd1 << 29)) >>> 30;
    if (acc > 64'sd2147483647 || acc < -64'sd2147483648) sat = 1'b1;
    return 32'(clip(acc, -64'sd2147483648, 64'sd2147483647));
  endfunction

  function automatic rotated_t rotate_vector(input logic [15:0] ang,
                                             input logic signed [15:0] ax, ay, az,
                                             input logic signed [31:0] vx, vy, vz);
    logic [31:0] turn;
    logic        flip;
    longint      x, y, z, nx, c, s, omc, kx, ky, kz;
    longint      m [9];
    longint      axx, ayy, azz, axy, axz, ayz, sx, sy, sz;
    rotated_t    r;
    turn = 32'(ang) << (32 - aavr_pkg::ANGLE_BITS);
    // second and third quadrants: rotate by half a turn and negate afterwards
    flip = turn[31] ^ turn[30];
    if (flip) turn = turn + 32'h8000_0000;
    z = longint'($signed(turn));
    x = 652032874;
    y = 0;
    for (int i = 0; i < aavr_pkg::CORDIC_N; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_TURNS[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_TURNS[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip(x, -Q30, Q30);
    s = clip(y, -Q30, Q30);
    omc = Q30 - c;
    kx = ax;
    ky = ay;
    kz = az;
    axx = (kx * kx * omc + (64'sd1 << 27)) >>> 28;
    ayy = (ky * ky * omc + (64'sd1 << 27)) >>> 28;
    azz = (kz * kz * omc + (64'sd1 << 27)) >>> 28;
    axy = (kx * ky * omc + (64'sd1 << 27)) >>> 28;
    axz = (kx * kz * omc + (64'sd1 << 27)) >>> 28;
    ayz = (ky * kz * omc + (64'sd1 << 27)) >>> 28;
    sx  = (s * kx + (64'sd1 << 13)) >>> 14;
    sy  = (s * ky + (64'sd1 << 13)) >>> 14;
    sz  = (s * kz + (64'sd1 << 13)) >>> 14;
    // matrix entries clip to [-1, 1] without raising the flag
    m[0] = clip(c + axx, -Q30, Q30);
    m[1] = clip(axy - sz, -Q30, Q30);
    m[2] = clip(axz + sy, -Q30, Q30);
    m[3] = clip(axy + sz, -Q30, Q30);
    m[4] = clip(c + ayy, -Q30, Q30);
    m[5] = clip(ayz - sx, -Q30, Q30);
    m[6] = clip(axz - sy, -Q30, Q30);
    m[7] = clip(ayz + sx, -Q30, Q30);
    m[8] = clip(c + azz, -Q30, Q30);
    r.sat = 1'b0;
    r.x = rotate_row(m[0], m[1], m[2], vx, vy, vz, r.sat);
    r.y = rotate_row(m[3], m[4], m[5], vx, vy, vz, r.sat);
    r.z = rotate_row(m[6], m[7], m[8], vx, vy, vz, r.sat);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    n_errors++;
    $display("mismatch at result %0d: %s got %0d expected %0d", n_results, what, got, want);
  endtask

  // one request: random hold-off, drive, wait for acceptance, predict
  task automatic send_request(input logic [15:0] ang,
                              input logic signed [15:0] ax, ay, az,
                              input logic signed [31:0] vx, vy, vz);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    angle  <= ang;
    axis_x <= ax;
    axis_y <= ay;
    axis_z <= az;
    vec_x  <= vx;
    vec_y  <= vy;
    vec_z  <= vz;
    do @(posedge clk); while (busy);
    rotated_q.push_back(rotate_vector(ang, ax, ay, az, vx, vy, vz));
    n_requests++;
  endtask

  // result checker: done marks one result for exactly one cycle
  always @(posedge clk) begin
    if (!rst && done) begin
      if (rotated_q.size() == 0) begin
        n_errors++;
        $display("unexpected result %0d with nothing pending", n_results);
      end else begin
        rotated_t want;
        want = rotated_q.pop_front();
        if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
        if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
        if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
        if (saturated !== want.sat)
          report_mismatch("saturated", 32'(saturated), 32'(want.sat));
        if (want.sat) n_sat++;
      end
      n_results++;
    end
  end

  // watchdog: far beyond every request taking the longest hold-off
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // quadrant boundaries and the extremes of the angle field
  task automatic test_quadrants();
    logic [15:0] angs [7] = '{16'h0000, 16'h0001, 16'h3fff, 16'h4000,
                              16'h8000, 16'hc000, 16'hffff};
    foreach (angs[i]) send_request(angs[i], 16'sd0, 16'sd0, 16'sd16384,
                                   32'sd65536, 32'sd131072, -32'sd65536);
  endtask

  // x axis forward and y axis reversed at a quarter turn, then the diagonal axis at an eighth turn
  task automatic test_axes();
    send_request(16'h4000, 16'sd16384, 16'sd0, 16'sd0, 32'sd1000, 32'sd65536, 32'sd0);
    send_request(16'h4000, 16'sd0, -16'sd16384, 16'sd0, 32'sd65536, 32'sd7, -32'sd3);
    send_request(16'h2000, 16'sd9459, 16'sd9459, 16'sd9459, 32'sd65536, 32'sd0, 32'sd0);
  endtask

  // extreme vectors, with and without output clipping
  task automatic test_extremes();
    send_request(16'h0000, 16'sd0, 16'sd0, 16'sd16384,
                 32'h7fff_ffff, 32'sh8000_0000, 32'sh8000_0000);
    send_request(16'h2000, 16'sd0, 16'sd0, 16'sd16384,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'sd0);
    send_request(16'h6000, 16'sd0, 16'sd0, 16'sd16384,
                 32'sh8000_0000, 32'sh8000_0000, 32'h7fff_ffff);
    send_request(16'h8000, 16'sd16384, 16'sd0, 16'sd0,
                 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
  endtask

  // non-unit axes, including the most negative and positive axis codes
  task automatic test_nonunit_axis();
    send_request(16'h1234, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sd65536, 32'sd65536, 32'sd65536);
    send_request(16'h9abc, 16'sh8000, 16'sh8000, 16'sh8000,
                 32'h7fff_ffff, 32'sh8000_0000, 32'sd1);
    send_request(16'h5555, 16'sh8000, 16'sh7fff, 16'sd0, 32'sd12345, -32'sd99999, 32'sd3);
    send_request(16'hffff, 16'sd0, 16'sd0, 16'sd0, -32'sd1, 32'sd1, 32'sd0);
  endtask

  function automatic logic signed [15:0] pick_axis_part(input int mode);
    case (mode)
      0: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      1: return 16'($signed($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_vec_part();
    if ($urandom_range(0, 3) == 0) return 32'($urandom);
    return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
  endfunction

  // random requests: half on a signed unit principal axis, the rest with in-range or arbitrary axis codes
  task automatic test_random(input int count);
    logic signed [15:0] ax, ay, az;
    int mode, which;
    for (int n = 0; n < count; n++) begin
      // runs of back-to-back requests between stretches with gaps
      if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      ax = 16'sd0;
      ay = 16'sd0;
      az = 16'sd0;
      if (mode < 5) begin
        which = $urandom_range(0, 2);
        if (which == 0) ax = pick_axis_part(0);
        else if (which == 1) ay = pick_axis_part(0);
        else az = pick_axis_part(0);
      end else if (mode < 8) begin
        ax = pick_axis_part(1);
        ay = pick_axis_part(1);
        az = pick_axis_part(1);
      end else begin
        ax = pick_axis_part(2);
        ay = pick_axis_part(2);
        az = pick_axis_part(2);
      end
      send_request(16'($urandom), ax, ay, az, pick_vec_part(), pick_vec_part(),
                   pick_vec_part());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    n_errors    = 0;
    n_requests  = 0;
    n_results   = 0;
    n_sat       = 0;
    cycle_count = 0;
    no_gaps     = 1'b0;
    rst    = 1'b1;
    start  = 1'b0;
    angle  = '0;
    axis_x = '0;
    axis_y = '0;
    axis_z = '0;
    vec_x  = '0;
    vec_y  = '0;
    vec_z  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_quadrants();
    test_axes();
    test_extremes();
    test_nonunit_axis();
    test_random(1530);
    start <= 1'b0;

    // drain the pipeline, then keep watching for stray results
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d rotation requests, %0d results, %0d with clipped output",
             n_requests, n_results, n_sat);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/aavr_pkg.sv
src/axis_angle_vector_rotate_unit.sv
test/tb_axis_angle_vector_rotate_unit.sv
